// File: design/apmc_pkg.sv
// Package for the amplifier pulse-mode controller.
// Holds the constants, codes and structs that the sequencer, result buffer and top level share.
`timescale 1ns / 1ps
`default_nettype none
package apmc_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int NUM_CH_EFF   = (NUM_CHANNELS < 4) ? NUM_CHANNELS : 4;

  localparam logic       OP_TICK = 1'b0;
  localparam logic       OP_REQ  = 1'b1;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_DISABLED  = 2'd1;
  localparam logic [1:0] STAT_BUSY      = 2'd2;
  localparam logic [1:0] STAT_UNCHANGED = 2'd3;

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_SHUT_OFF = 3'd1;
  localparam logic [2:0] PH_SHUT_ON  = 3'd2;
  localparam logic [2:0] PH_START    = 3'd3;
  localparam logic [2:0] PH_GAP      = 3'd4;
  localparam logic [2:0] PH_PHI      = 3'd5;
  localparam logic [2:0] PH_PLO      = 3'd6;
  localparam logic [2:0] PH_WORK     = 3'd7;

  localparam logic [1:0] REG_AMP_TYPE      = 2'd0;
  localparam logic [1:0] REG_MODE_OVERRIDE = 2'd1;
  localparam logic [1:0] REG_DISABLED_CH   = 2'd2;
  localparam logic [1:0] REG_CHANNEL_MODES = 2'd3;

  localparam logic [9:0] T_START       = 10'd300;
  localparam logic [9:0] T_WORK        = 10'd300;
  localparam logic [9:0] T_PULSE_START = 10'd20;
  localparam logic [9:0] T_PULSE_OTHER = 10'd5;
  localparam logic [9:0] T_PWD_START   = 10'd260;
  localparam logic [9:0] T_PWD_OTHER   = 10'd1000;
  localparam logic [3:0] MODE_MAX      = 4'd10;

  typedef struct packed {
    logic              use_second_amp_type;
    logic [3:0]        mode_override;
    logic signed [2:0] disabled_channel;
    logic [15:0]       channel_modes;
  } cfg_t;

  typedef struct packed {
    logic       opcode;
    logic [1:0] channel;
    logic       turn_on;
  } in_item_t;

  typedef struct packed {
    logic [3:0] pin_levels;
    logic       busy_res;
    logic [1:0] status;
    logic [3:0] amp_on_flags;
  } res_t;

endpackage
`default_nettype wire

// File: design/apmc_in_if.sv
// Input channel interface of the pulse-mode controller: valid, ready and the request item.
// Standalone; the payload widths follow the item fields.
`timescale 1ns / 1ps
`default_nettype none
interface apmc_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [1:0] channel;
  logic       turn_on;

  modport source (output valid, output opcode, output channel, output turn_on, input ready);
  modport sink (input valid, input opcode, input channel, input turn_on, output ready);
endinterface
`default_nettype wire

// File: design/apmc_out_if.sv
// Result channel interface of the pulse-mode controller: valid, ready and the result item.
// Standalone; the payload widths follow the result fields.
`timescale 1ns / 1ps
`default_nettype none
interface apmc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] pin_levels;
  logic       busy_res;
  logic [1:0] status;
  logic [3:0] amp_on_flags;

  modport source (output valid, output pin_levels, output busy_res, output status,
                  output amp_on_flags, input ready);
  modport sink (input valid, input pin_levels, input busy_res, input status,
                input amp_on_flags, output ready);
endinterface
`default_nettype wire

// File: design/amp_pulse_mode_controller_unit.sv
// Top level of the amplifier pulse-mode controller: input register, configuration registers,
// sequencer and result buffer. Uses apmc_pkg, apmc_in_if, apmc_out_if, apmc_seq and apmc_res_buf.
//
// The block takes one item per clock cycle while the result buffer has space. An accepted tick
// or request is held in the input register, is applied to the channel state by the sequencer,
// and its result is written into a two-entry buffer, from which it can then be taken. An item
// waits in the input register while the buffer is full; the buffer lets input continue while
// up to two results wait at the output. Every item gives exactly one result.
// Configuration registers may be written only while no item is in
// flight; a sequence that is running picks up the new values at its next step.
`timescale 1ns / 1ps
`default_nettype none
module amp_pulse_mode_controller_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  apmc_in_if.sink          in_ch,
  apmc_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  import apmc_pkg::*;

  cfg_t     cfg_r;
  logic     s0_valid_r;
  in_item_t s0_item_r;
  logic     buf_space;
  logic     fire;
  res_t     seq_res;
  res_t     out_res;
  logic     in_fire;

  assign fire        = s0_valid_r && buf_space;
  assign in_ch.ready = !s0_valid_r || fire;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.use_second_amp_type <= 1'b0;
      cfg_r.mode_override       <= '0;
      cfg_r.disabled_channel    <= -3'sd1;
      cfg_r.channel_modes       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AMP_TYPE:      cfg_r.use_second_amp_type <= cfg_wdata[0];
        REG_MODE_OVERRIDE: cfg_r.mode_override       <= cfg_wdata[3:0];
        REG_DISABLED_CH:   cfg_r.disabled_channel    <= cfg_wdata[2:0];
        REG_CHANNEL_MODES: cfg_r.channel_modes       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s0_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_item_r.opcode  <= in_ch.opcode;
      s0_item_r.channel <= in_ch.channel;
      s0_item_r.turn_on <= in_ch.turn_on;
    end
  end

  apmc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (s0_item_r),
    .cfg   (cfg_r),
    .res   (seq_res)
  );

  apmc_res_buf u_res_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .push_data (seq_res),
    .space     (buf_space),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_res)
  );

  assign out_ch.pin_levels   = out_res.pin_levels;
  assign out_ch.busy_res     = out_res.busy_res;
  assign out_ch.status       = out_res.status;
  assign out_ch.amp_on_flags = out_res.amp_on_flags;
endmodule
`default_nettype wire

// File: design/apmc_seq.sv
// Sequencer of the pulse-mode controller: channel state, pulse and delay counters.
// Uses apmc_pkg; one item is applied in the cycle that fire is high.
`timescale 1ns / 1ps
`default_nettype none
module apmc_seq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fire,
  input  wire apmc_pkg::in_item_t item,
  input  wire apmc_pkg::cfg_t     cfg,
  output apmc_pkg::res_t          res
);
  import apmc_pkg::*;

  logic [3:0] pin_r, pin_nxt;
  logic [3:0] amp_on_r, amp_on_nxt;
  logic [3:0] last_mode_r, last_mode_nxt;
  logic [1:0] last_ch_r, last_ch_nxt;
  logic [2:0] phase_r, phase_nxt;
  logic [3:0] pulses_r, pulses_nxt;
  logic [9:0] delay_r, delay_nxt;
  logic [1:0] act_ch_r, act_ch_nxt;
  logic [1:0] status;

  always_comb begin
    logic [3:0] mode;
    logic [9:0] delay_dec;
    logic [9:0] pulse_time;
    logic [9:0] pwd_time;
    logic       do_begin;
    pin_nxt       = pin_r;
    amp_on_nxt    = amp_on_r;
    last_mode_nxt = last_mode_r;
    last_ch_nxt   = last_ch_r;
    phase_nxt     = phase_r;
    pulses_nxt    = pulses_r;
    delay_nxt     = delay_r;
    act_ch_nxt    = act_ch_r;
    status        = STAT_OK;
    mode          = '0;
    delay_dec     = '0;
    do_begin      = 1'b0;
    pulse_time    = cfg.use_second_amp_type ? T_PULSE_START : T_PULSE_OTHER;
    pwd_time      = cfg.use_second_amp_type ? T_PWD_START : T_PWD_OTHER;
    if (fire) begin
      if (item.opcode == OP_REQ) begin
        if (!cfg.disabled_channel[2] && (cfg.disabled_channel[1:0] == item.channel)) begin
          status = STAT_DISABLED;
        end else if ({1'b0, item.channel} >= 3'(NUM_CH_EFF)) begin
          status = STAT_DISABLED;
        end else if (phase_r != PH_IDLE) begin
          status = STAT_BUSY;
        end else begin
          amp_on_nxt[item.channel] = item.turn_on;
          if (!item.turn_on) begin
            act_ch_nxt            = item.channel;
            last_mode_nxt         = 4'd1;
            last_ch_nxt           = 2'd0;
            pin_nxt[item.channel] = 1'b0;
            delay_nxt             = pwd_time;
            phase_nxt             = PH_SHUT_OFF;
          end else begin
            mode = cfg.channel_modes[{item.channel, 2'b00} +: 4];
            if (mode > MODE_MAX) begin
              mode = 4'd0;
            end
            if (cfg.mode_override != 4'd0) begin
              mode = cfg.mode_override;
            end
            if ((mode == last_mode_r) && (item.channel == last_ch_r)) begin
              status = STAT_UNCHANGED;
            end else begin
              act_ch_nxt            = item.channel;
              pin_nxt[item.channel] = 1'b0;
              delay_nxt             = pwd_time;
              last_mode_nxt         = mode;
              last_ch_nxt           = item.channel;
              pulses_nxt            = (mode >= 4'd2) ? (mode - 4'd1) : 4'd0;
              phase_nxt             = PH_SHUT_ON;
            end
          end
        end
      end else if (phase_r != PH_IDLE) begin
        delay_dec = (delay_r == 10'd0) ? 10'd0 : (delay_r - 10'd1);
        delay_nxt = delay_dec;
        if (delay_dec == 10'd0) begin
          unique case (phase_r)
            PH_SHUT_ON: begin
              if (cfg.use_second_amp_type) begin
                pin_nxt[act_ch_r] = 1'b1;
                delay_nxt         = T_START;
                phase_nxt         = PH_START;
              end else begin
                do_begin = 1'b1;
              end
            end
            PH_START: begin
              pin_nxt[act_ch_r] = 1'b0;
              delay_nxt         = T_PULSE_START;
              phase_nxt         = PH_GAP;
            end
            PH_GAP: begin
              do_begin = 1'b1;
            end
            PH_PHI: begin
              pin_nxt[act_ch_r] = 1'b0;
              delay_nxt         = pulse_time;
              phase_nxt         = PH_PLO;
            end
            PH_PLO: begin
              if (pulses_r != 4'd0) begin
                pulses_nxt = pulses_r - 4'd1;
              end
              do_begin = 1'b1;
            end
            default: begin
              delay_nxt = 10'd0;
              phase_nxt = PH_IDLE;
            end
          endcase
          if (do_begin) begin
            pin_nxt[act_ch_r] = 1'b1;
            if (pulses_nxt != 4'd0) begin
              delay_nxt = pulse_time;
              phase_nxt = PH_PHI;
            end else if (cfg.use_second_amp_type) begin
              delay_nxt = T_WORK;
              phase_nxt = PH_WORK;
            end else begin
              delay_nxt = 10'd0;
              phase_nxt = PH_IDLE;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_r       <= '0;
      amp_on_r    <= '0;
      last_mode_r <= 4'd1;
      last_ch_r   <= '0;
      phase_r     <= PH_IDLE;
      pulses_r    <= '0;
      delay_r     <= '0;
      act_ch_r    <= '0;
    end else begin
      pin_r       <= pin_nxt;
      amp_on_r    <= amp_on_nxt;
      last_mode_r <= last_mode_nxt;
      last_ch_r   <= last_ch_nxt;
      phase_r     <= phase_nxt;
      pulses_r    <= pulses_nxt;
      delay_r     <= delay_nxt;
      act_ch_r    <= act_ch_nxt;
    end
  end

  assign res.pin_levels   = pin_nxt;
  assign res.busy_res     = (phase_nxt != PH_IDLE);
  assign res.status       = status;
  assign res.amp_on_flags = amp_on_nxt;

`ifndef SYNTHESIS
  // A running sequence always has time left on its delay, and an idle one none.
  a_busy_has_delay: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) |-> (delay_r != 10'd0))
    else $error("sequence running with an empty delay");
  a_idle_no_delay: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (delay_r == 10'd0))
    else $error("idle with a pending delay");
  a_busy_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (status == STAT_BUSY)) |-> (phase_r != PH_IDLE))
    else $error("request rejected while idle");
  a_idle_tick_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (item.opcode == OP_TICK) && (phase_r == PH_IDLE)) |=>
      ($stable(pin_r) && (phase_r == PH_IDLE)))
    else $error("tick while idle changed the pins");
`endif
endmodule
`default_nettype wire

// File: design/apmc_res_buf.sv
// Two-entry result buffer of the pulse-mode controller, between the sequencer and the result channel.
// Uses apmc_pkg for the result struct.
`timescale 1ns / 1ps
`default_nettype none
module apmc_res_buf (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire apmc_pkg::res_t push_data,
  output logic               space,
  output logic               out_valid,
  input  wire logic          out_ready,
  output apmc_pkg::res_t      out_data
);
  import apmc_pkg::*;

  logic [1:0] count_r, count_nxt;
  res_t       head_r;
  res_t       tail_r;
  logic       pop;

  assign space     = (count_r != 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = head_r;
  assign pop       = out_valid && out_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && (count_r == 2'd1)) begin
        head_r <= push_data;
      end else begin
        head_r <= tail_r;
        if (push) begin
          tail_r <= push_data;
        end
      end
    end else if (push) begin
      if (count_r == 2'd0) begin
        head_r <= push_data;
      end else begin
        tail_r <= push_data;
      end
    end
  end
endmodule
`default_nettype wire

// File: tb/amp_pulse_mode_controller_unit_test.sv
// Self-checking bench for amp_pulse_mode_controller_unit: ticks and on/off requests with random
// gaps on both channels, each result checked against a tick-exact model of the pin sequencer.
// Depends on apmc_pkg, apmc_in_if, apmc_out_if and the controller RTL.
`timescale 1ns / 1ps
module amp_pulse_mode_controller_unit_test;
  import apmc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_WAIT  = 8;
  localparam int TAIL_ITEMS  = 12;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = REG_AMP_TYPE;
  logic [15:0] cfg_wdata = '0;

  apmc_in_if  in_bus();
  apmc_out_if out_bus();

  amp_pulse_mode_controller_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sequencer state as the block should hold it.
  cfg_t       reg_copy;
  logic [3:0] pin_state;
  logic [3:0] on_flags;
  logic [3:0] prev_mode;
  logic [1:0] prev_channel;
  logic [2:0] seq_phase;
  logic [3:0] pulses_to_go;
  logic [9:0] hold_ticks;
  logic [1:0] seq_channel;

  in_item_t items_to_send[$];
  res_t     expected_reports[$];
  in_item_t next_item;
  res_t     due;

  int   queued_count   = 0;
  int   accepted_count = 0;
  int   checked_count  = 0;
  int   cycle_count    = 0;
  int   errors         = 0;
  int   send_gap       = 0;
  int   recv_gap       = 0;
  int   hold_left      = 0;
  int   holds_asked    = 0;
  int   holds_served   = 0;
  bit   send_idling    = 1'b0;
  bit   recv_idling    = 1'b0;
  logic in_fire        = 1'b0;
  logic out_fire       = 1'b0;

  function automatic int draw_idle(input bit enabled);
    return enabled ? int'($urandom_range(0, 5)) : 0;
  endfunction

  function automatic logic [9:0] pulse_width();
    return reg_copy.use_second_amp_type ? T_PULSE_START : T_PULSE_OTHER;
  endfunction

  function automatic void start_shutdown();
    prev_mode = 4'd1;
    prev_channel = 2'd0;
    pin_state[seq_channel] = 1'b0;
    hold_ticks = reg_copy.use_second_amp_type ? T_PWD_START : T_PWD_OTHER;
  endfunction

  function automatic void pulse_or_final_high();
    pin_state[seq_channel] = 1'b1;
    if (pulses_to_go != 0) begin
      hold_ticks = pulse_width();
      seq_phase = PH_PHI;
    end else if (reg_copy.use_second_amp_type) begin
      hold_ticks = T_WORK;
      seq_phase = PH_WORK;
    end else begin
      hold_ticks = '0;
      seq_phase = PH_IDLE;
    end
  endfunction

  function automatic logic [1:0] take_request(input logic [1:0] ch, input logic on);
    logic [3:0] chan_mode;
    if (!reg_copy.disabled_channel[2] && reg_copy.disabled_channel[1:0] == ch)
      return STAT_DISABLED;
    if (ch >= NUM_CH_EFF)
      return STAT_DISABLED;
    if (seq_phase != PH_IDLE)
      return STAT_BUSY;
    on_flags[ch] = on;
    if (!on) begin
      seq_channel = ch;
      start_shutdown();
      seq_phase = PH_SHUT_OFF;
      return STAT_OK;
    end
    chan_mode = reg_copy.channel_modes[4 * ch +: 4];
    if (chan_mode > MODE_MAX)
      chan_mode = 4'd0;
    if (reg_copy.mode_override != 4'd0)
      chan_mode = reg_copy.mode_override;
    if (chan_mode == prev_mode && ch == prev_channel)
      return STAT_UNCHANGED;
    seq_channel = ch;
    start_shutdown();
    prev_mode = chan_mode;
    prev_channel = ch;
    pulses_to_go = (chan_mode >= 4'd2) ? chan_mode - 4'd1 : 4'd0;
    seq_phase = PH_SHUT_ON;
    return STAT_OK;
  endfunction

  function automatic res_t step_pulse_sequencer(input in_item_t it);
    res_t r;
    r.status = STAT_OK;
    if (it.opcode == OP_REQ) begin
      r.status = take_request(it.channel, it.turn_on);
    end else if (seq_phase != PH_IDLE) begin
      if (hold_ticks != 0)
        hold_ticks = hold_ticks - 10'd1;
      if (hold_ticks == 0) begin
        case (seq_phase)
          PH_SHUT_ON: begin
            if (reg_copy.use_second_amp_type) begin
              pin_state[seq_channel] = 1'b1;
              hold_ticks = T_START;
              seq_phase = PH_START;
            end else begin
              pulse_or_final_high();
            end
          end
          PH_START: begin
            pin_state[seq_channel] = 1'b0;
            hold_ticks = T_PULSE_START;
            seq_phase = PH_GAP;
          end
          PH_GAP: begin
            pulse_or_final_high();
          end
          PH_PHI: begin
            pin_state[seq_channel] = 1'b0;
            hold_ticks = pulse_width();
            seq_phase = PH_PLO;
          end
          PH_PLO: begin
            if (pulses_to_go != 0)
              pulses_to_go = pulses_to_go - 4'd1;
            pulse_or_final_high();
          end
          default: begin
            hold_ticks = '0;
            seq_phase = PH_IDLE;
          end
        endcase
      end
    end
    r.pin_levels = pin_state;
    r.busy_res = (seq_phase != PH_IDLE);
    r.amp_on_flags = on_flags;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [3:0] want,
                                      input logic [3:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Input side: one item per handshake, with a drawn gap before each one.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (in_fire || !in_bus.valid) begin
      if (in_fire)
        send_gap = draw_idle(send_idling);
      if (send_gap > 0) begin
        send_gap--;
        in_bus.valid <= 1'b0;
      end else if (items_to_send.size() != 0) begin
        next_item = items_to_send.pop_front();
        in_bus.opcode <= next_item.opcode;
        in_bus.channel <= next_item.channel;
        in_bus.turn_on <= next_item.turn_on;
        in_bus.valid <= 1'b1;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Result side: drawn stalls per item, plus long hold-offs on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = LONG_HOLD;
      out_bus.ready <= 1'b0;
    end else if (out_fire || !out_bus.ready) begin
      if (out_fire)
        recv_gap = draw_idle(recv_idling);
      if (recv_gap > 0) begin
        recv_gap--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    out_fire = rst_n && out_bus.valid && out_bus.ready;
    in_fire = rst_n && in_bus.valid && in_bus.ready;
    if (out_fire) begin
      checked_count++;
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t: no result expected, got pins %0d busy %0d status %0d flags %0d",
                 $time, out_bus.pin_levels, out_bus.busy_res, out_bus.status,
                 out_bus.amp_on_flags);
      end else begin
        due = expected_reports.pop_front();
        check_field("pin_levels", due.pin_levels, out_bus.pin_levels);
        check_field("busy_res", 4'(due.busy_res), 4'(out_bus.busy_res));
        check_field("status", 4'(due.status), 4'(out_bus.status));
        check_field("amp_on_flags", due.amp_on_flags, out_bus.amp_on_flags);
      end
    end
    if (in_fire) begin
      next_item.opcode = in_bus.opcode;
      next_item.channel = in_bus.channel;
      next_item.turn_on = in_bus.turn_on;
      expected_reports.push_back(step_pulse_sequencer(next_item));
      accepted_count++;
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  task automatic send(input logic op, input logic [1:0] ch, input logic on);
    in_item_t it;
    it.opcode = op;
    it.channel = ch;
    it.turn_on = on;
    items_to_send.push_back(it);
    queued_count++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send(OP_TICK, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
  endtask

  task automatic run_to_idle();
    wait (accepted_count == queued_count);
    while (seq_phase != PH_IDLE) begin
      send_ticks(hold_ticks > 1 ? int'(hold_ticks) : 1);
      wait (accepted_count == queued_count);
    end
  endtask

  task automatic drain();
    wait (accepted_count == queued_count);
    wait (checked_count == accepted_count);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_AMP_TYPE:      reg_copy.use_second_amp_type = value[0];
      REG_MODE_OVERRIDE: reg_copy.mode_override = value[3:0];
      REG_DISABLED_CH:   reg_copy.disabled_channel = value[2:0];
      default:           reg_copy.channel_modes = value;
    endcase
  endtask

  initial begin
    in_bus.valid = 1'b0;
    in_bus.opcode = OP_TICK;
    in_bus.channel = 2'd0;
    in_bus.turn_on = 1'b0;
    out_bus.ready = 1'b0;
    reg_copy.use_second_amp_type = 1'b0;
    reg_copy.mode_override = 4'd0;
    reg_copy.disabled_channel = -3'sd1;
    reg_copy.channel_modes = 16'h0000;
    pin_state = 4'd0;
    on_flags = 4'd0;
    prev_mode = 4'd1;
    prev_channel = 2'd0;
    seq_phase = PH_IDLE;
    pulses_to_go = 4'd0;
    hold_ticks = 10'd0;
    seq_channel = 2'd0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Short shutdown of the start-pulse type, then 5 us pulses once the type is switched.
    send_idling = 1'b1;
    recv_idling = 1'b1;
    write_reg(REG_AMP_TYPE, 16'd1);
    write_reg(REG_MODE_OVERRIDE, 16'd0);
    write_reg(REG_DISABLED_CH, 16'd3);
    write_reg(REG_CHANNEL_MODES, 16'hF2A1);
    send(OP_REQ, 2'd0, 1'b1);
    send(OP_REQ, 2'd3, 1'b1);
    send(OP_REQ, 2'd2, 1'b1);
    send(OP_REQ, 2'd1, 1'b0);
    send_ticks(3);
    drain();
    write_reg(REG_AMP_TYPE, 16'd0);
    holds_asked++;
    run_to_idle();
    drain();

    // Shutdown while further requests are refused, with items sent back to back.
    send_idling = 1'b0;
    recv_idling = 1'b0;
    write_reg(REG_AMP_TYPE, 16'd1);
    send(OP_REQ, 2'd2, 1'b0);
    send(OP_REQ, 2'd0, 1'b1);
    holds_asked++;
    run_to_idle();
    send(OP_REQ, 2'd0, 1'b1);
    drain();

    // An override above ten turns an unchanged request into a new sequence.
    send_idling = 1'b1;
    recv_idling = 1'b1;
    write_reg(REG_MODE_OVERRIDE, 16'd15);
    write_reg(REG_DISABLED_CH, 16'd7);
    send(OP_REQ, 2'd0, 1'b1);
    for (int n = 0; n < TAIL_ITEMS; n++) begin
      if ($urandom_range(0, 2) == 0)
        send(OP_REQ, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      else
        send_ticks(1);
    end

    drain();
    if (errors == 0 && expected_reports.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
